FILE: rtl/core/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants of the RC4 stream cipher core: function codes,
// permutation port selects and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned PermSize = 256;
  localparam int unsigned FuncW    = 2;

  typedef enum logic [FuncW-1:0] {
    FUNC_KEY  = 2'd0,
    FUNC_DATA = 2'd1,
    FUNC_KS   = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    RA_N     = 3'd0,
    RA_SCH_J = 3'd1,
    RA_GEN_I = 3'd2,
    RA_GEN_J = 3'd3,
    RA_SUM   = 3'd4
  } rd_addr_e;

  typedef enum logic [1:0] {
    WA_N = 2'd0,
    WA_I = 2'd1,
    WA_J = 2'd2
  } wr_addr_e;

  typedef struct packed {
    logic     take;
    logic     key_wr;
    logic     sch_start;
    logic     sch_step;
    logic     sch_done;
    logic     rd_en;
    rd_addr_e rd_addr;
    logic     wr_en;
    wr_addr_e wr_addr;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic n_last;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/core/rc4_in_if.sv
// ----------------------------------------------------------------------------
// rc4_in_if
// Input channel: function code, data or key byte and last flag per beat.
// ----------------------------------------------------------------------------
interface rc4_in_if;
  logic                      valid;
  logic                      ready;
  logic [rc4_pkg::FuncW-1:0] func;
  logic [rc4_pkg::ByteW-1:0] data_in;
  logic                      last;

  modport source (output valid, func, data_in, last, input ready);
  modport sink   (input valid, func, data_in, last, output ready);
endinterface

FILE: rtl/core/rc4_out_if.sv
// ----------------------------------------------------------------------------
// rc4_out_if
// Output channel: processed or keystream byte and last flag per beat.
// ----------------------------------------------------------------------------
interface rc4_out_if;
  logic                      valid;
  logic                      ready;
  logic [rc4_pkg::ByteW-1:0] data_out;
  logic                      last_out;

  modport source (output valid, data_out, last_out, input ready);
  modport sink   (input valid, data_out, last_out, output ready);
endinterface

FILE: rtl/core/rc4_stream_cipher_core.sv
// Data or keystream beat: no new beat is taken until its result is loaded into
// the output register; the single-port permutation memory sets the pace.
// Key byte: stored on accept if there is room. Last key byte: runs the key
// schedule. Reset: asynchronous, active low; permutation reads as identity
// through per-entry valid bits, indices and key count clear, no init pass.
// ----------------------------------------------------------------------------
// rc4_stream_cipher_core
// RC4 engine: key load, key schedule and keystream generation.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_core #(
  parameter int unsigned KeyBytesMax = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rc4_in_if.sink   in_i,
  rc4_out_if.source out_o
);

  rc4_pkg::dp_cmd_t    cmd;
  rc4_pkg::dp_status_t status;

  rc4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .func_i     (in_i.func),
    .last_i     (in_i.last),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rc4_datapath #(
    .KeyBytesMax (KeyBytesMax)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .func_i      (in_i.func),
    .data_in_i   (in_i.data_in),
    .last_i      (in_i.last),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .data_out_o  (out_o.data_out),
    .last_out_o  (out_o.last_out)
  );

endmodule

FILE: rtl/core/rc4_datapath.sv
// ----------------------------------------------------------------------------
// rc4_datapath
// Key store, permutation memory with per-entry valid bits, generator and
// schedule indices, and the output register.
// ----------------------------------------------------------------------------
module rc4_datapath #(
  parameter int unsigned KeyBytesMax = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rc4_pkg::dp_cmd_t          cmd_i,
  output rc4_pkg::dp_status_t       status_o,
  input  logic [rc4_pkg::FuncW-1:0] func_i,
  input  logic [rc4_pkg::ByteW-1:0] data_in_i,
  input  logic                      last_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [rc4_pkg::ByteW-1:0] data_out_o,
  output logic                      last_out_o
);

  localparam int unsigned KeyIdxW = (KeyBytesMax > 1) ? $clog2(KeyBytesMax) : 1;
  localparam int unsigned CntW    = $clog2(KeyBytesMax + 1);
  localparam int unsigned BW      = rc4_pkg::ByteW;

  logic [BW-1:0]                  perm_mem [rc4_pkg::PermSize];
  logic [rc4_pkg::PermSize-1:0]   perm_vld_q;
  logic [BW-1:0]                  perm_rd_q;
  logic                           rd_vld_q;
  logic [BW-1:0]                  rd_addr_q;
  logic [BW-1:0]                  key_mem [KeyBytesMax];
  logic [BW-1:0]                  key_rd_q;

  logic [BW-1:0]                  i_q, j_q, n_q;
  logic [KeyIdxW-1:0]             kidx_q;
  logic [CntW-1:0]                key_count_q;
  logic [BW-1:0]                  si_q, sj_q;
  logic [rc4_pkg::FuncW-1:0]      func_q;
  logic [BW-1:0]                  data_q;
  logic                           last_q;
  logic                           out_valid_q;
  logic [BW-1:0]                  out_data_q;
  logic                           out_last_q;

  logic [BW-1:0]                  rd_data;
  logic [BW-1:0]                  rd_addr;
  logic [BW-1:0]                  wr_addr;
  logic [BW-1:0]                  wr_data;
  logic [BW-1:0]                  i_inc;
  logic [BW-1:0]                  j_sch;
  logic [BW-1:0]                  j_gen;
  logic [CntW-1:0]                key_len;
  logic [CntW-1:0]                kidx_inc;
  logic                           key_room;

  assign rd_data  = rd_vld_q ? perm_rd_q : rd_addr_q;
  assign i_inc    = i_q + BW'(1);
  assign j_sch    = j_q + rd_data + key_rd_q;
  assign j_gen    = j_q + rd_data;
  assign key_len  = (key_count_q == '0) ? CntW'(1) : key_count_q;
  assign kidx_inc = CntW'(kidx_q) + CntW'(1);
  assign key_room = key_count_q < CntW'(KeyBytesMax);

  always_comb begin
    unique case (cmd_i.rd_addr)
      rc4_pkg::RA_N:     rd_addr = n_q;
      rc4_pkg::RA_SCH_J: rd_addr = j_sch;
      rc4_pkg::RA_GEN_I: rd_addr = i_inc;
      rc4_pkg::RA_GEN_J: rd_addr = j_gen;
      rc4_pkg::RA_SUM:   rd_addr = si_q + sj_q;
      default:           rd_addr = n_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.wr_addr)
      rc4_pkg::WA_N: wr_addr = n_q;
      rc4_pkg::WA_I: wr_addr = i_q;
      rc4_pkg::WA_J: wr_addr = j_q;
      default:       wr_addr = n_q;
    endcase
  end

  assign wr_data = (cmd_i.wr_addr == rc4_pkg::WA_J) ? si_q : rd_data;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      perm_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      perm_rd_q <= perm_mem[rd_addr];
      rd_vld_q  <= perm_vld_q[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_wr && key_room) begin
      key_mem[key_count_q[KeyIdxW-1:0]] <= data_in_i;
    end
    key_rd_q <= key_mem[kidx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      perm_vld_q <= '0;
    end else if (cmd_i.sch_start) begin
      perm_vld_q <= '0;
    end else if (cmd_i.wr_en) begin
      perm_vld_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      kidx_q      <= '0;
      key_count_q <= '0;
    end else begin
      if (cmd_i.key_wr && key_room) begin
        key_count_q <= key_count_q + CntW'(1);
      end
      priority if (cmd_i.sch_start) begin
        j_q    <= '0;
        n_q    <= '0;
        kidx_q <= '0;
      end else if (cmd_i.sch_done) begin
        i_q         <= '0;
        j_q         <= '0;
        n_q         <= n_q + BW'(1);
        key_count_q <= '0;
      end else if (cmd_i.sch_step) begin
        n_q <= n_q + BW'(1);
      end else if (cmd_i.rd_en && cmd_i.rd_addr == rc4_pkg::RA_SCH_J) begin
        j_q    <= j_sch;
        kidx_q <= (kidx_inc == key_len) ? '0 : kidx_inc[KeyIdxW-1:0];
      end else if (cmd_i.rd_en && cmd_i.rd_addr == rc4_pkg::RA_GEN_I) begin
        i_q <= i_inc;
      end else if (cmd_i.rd_en && cmd_i.rd_addr == rc4_pkg::RA_GEN_J) begin
        j_q <= j_gen;
      end else begin
        j_q <= j_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      func_q <= func_i;
      data_q <= data_in_i;
      last_q <= last_i;
    end
    if (cmd_i.rd_en &&
        (cmd_i.rd_addr == rc4_pkg::RA_SCH_J || cmd_i.rd_addr == rc4_pkg::RA_GEN_J)) begin
      si_q <= rd_data;
    end
    if (cmd_i.wr_en && cmd_i.wr_addr == rc4_pkg::WA_I) begin
      sj_q <= rd_data;
    end
    if (cmd_i.out_load) begin
      out_data_q <= (func_q == rc4_pkg::FUNC_KS) ? rd_data : (rd_data ^ data_q);
      out_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.n_last   = (n_q == '1);
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign data_out_o        = out_data_q;
  assign last_out_o        = out_last_q;

endmodule

FILE: rtl/core/rc4_ctrl.sv
// ----------------------------------------------------------------------------
// rc4_ctrl
// Sequencer for key loading, the 256-round key schedule and the generator
// step; each access state drives one read or one write of the permutation memory.
// ----------------------------------------------------------------------------
module rc4_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [rc4_pkg::FuncW-1:0] func_i,
  input  logic                      last_i,
  output logic                      in_ready_o,
  input  rc4_pkg::dp_status_t       status_i,
  output rc4_pkg::dp_cmd_t          cmd_o
);

  typedef enum logic [12:0] {
    ST_IDLE     = 13'b0000000000001,
    ST_SCH_INIT = 13'b0000000000010,
    ST_SCH_RD_N = 13'b0000000000100,
    ST_SCH_RD_J = 13'b0000000001000,
    ST_SCH_WR_N = 13'b0000000010000,
    ST_SCH_WR_J = 13'b0000000100000,
    ST_GEN_RD_I = 13'b0000001000000,
    ST_GEN_RD_J = 13'b0000010000000,
    ST_GEN_WR_I = 13'b0000100000000,
    ST_GEN_WR_J = 13'b0001000000000,
    ST_GEN_RD_S = 13'b0010000000000,
    ST_GEN_DONE = 13'b0100000000000,
    ST_SPARE    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.rd_addr = rc4_pkg::RA_N;
    cmd_o.wr_addr = rc4_pkg::WA_N;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          unique case (func_i)
            rc4_pkg::FUNC_KEY: begin
              cmd_o.key_wr = 1'b1;
              if (last_i) begin
                state_d = ST_SCH_INIT;
              end
            end
            rc4_pkg::FUNC_DATA,
            rc4_pkg::FUNC_KS: state_d = ST_GEN_RD_I;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCH_INIT: begin
        cmd_o.sch_start = 1'b1;
        state_d         = ST_SCH_RD_N;
      end
      ST_SCH_RD_N: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = rc4_pkg::RA_N;
        state_d       = ST_SCH_RD_J;
      end
      ST_SCH_RD_J: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = rc4_pkg::RA_SCH_J;
        state_d       = ST_SCH_WR_N;
      end
      ST_SCH_WR_N: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = rc4_pkg::WA_N;
        state_d       = ST_SCH_WR_J;
      end
      ST_SCH_WR_J: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = rc4_pkg::WA_J;
        if (status_i.n_last) begin
          cmd_o.sch_done = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          cmd_o.sch_step = 1'b1;
          state_d        = ST_SCH_RD_N;
        end
      end
      ST_GEN_RD_I: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = rc4_pkg::RA_GEN_I;
        state_d       = ST_GEN_RD_J;
      end
      ST_GEN_RD_J: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = rc4_pkg::RA_GEN_J;
        state_d       = ST_GEN_WR_I;
      end
      ST_GEN_WR_I: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = rc4_pkg::WA_I;
        state_d       = ST_GEN_WR_J;
      end
      ST_GEN_WR_J: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = rc4_pkg::WA_J;
        state_d       = ST_GEN_RD_S;
      end
      ST_GEN_RD_S: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = rc4_pkg::RA_SUM;
        state_d       = ST_GEN_DONE;
      end
      ST_GEN_DONE: begin
        // hold the keystream byte until the output register frees up
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rc4_stream_cipher_core. A table of directed beats
// covers reset state, known key vectors, key overflow and the unused function
// code. A long random run of key loads and data runs with noise follows.
// A byte-level model predicts every output beat. Both channels
// throttle at random, and the output is held off once to fill the core.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned ByteW        = rc4_pkg::ByteW;
  localparam int unsigned FuncW        = rc4_pkg::FuncW;
  localparam int unsigned PermSize     = rc4_pkg::PermSize;
  localparam int unsigned KeyMax       = 32;
  localparam int          HalfPeriod   = 5;
  localparam int          ClkPeriod    = 2 * HalfPeriod;
  localparam int          ResetCycles  = 7;
  localparam int          NumRandom    = 1300;
  localparam int          PhaseTwoAt   = 500;
  localparam int          PhaseThreeAt = 1000;
  localparam int          HoldCycles   = 400;
  localparam int          DrainCycles  = 1100;
  localparam int          LimitCycles  = 1000000;
  localparam logic [FuncW-1:0] FuncNone = 2'd3;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [ByteW-1:0] data;
    logic             last;
    logic [7:0]       reps;
    logic             known;
    logic [ByteW-1:0] exp;
  } stim_row_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } cipher_out_t;

  localparam int NumRows = 25;
  localparam stim_row_t DirRows [NumRows] = '{
    '{rc4_pkg::FUNC_KS,   8'h00, 1'b0, 8'd1,  1'b1, 8'h02},
    '{rc4_pkg::FUNC_KS,   8'hFF, 1'b1, 8'd1,  1'b1, 8'h05},
    '{rc4_pkg::FUNC_DATA, 8'hFF, 1'b0, 8'd1,  1'b1, 8'hF8},
    '{FuncNone,           8'hAA, 1'b1, 8'd1,  1'b0, 8'h00},
    '{rc4_pkg::FUNC_DATA, 8'h00, 1'b1, 8'd1,  1'b0, 8'h00},
    '{rc4_pkg::FUNC_KEY,  8'h00, 1'b1, 8'd1,  1'b0, 8'h00},
    '{rc4_pkg::FUNC_KS,   8'h00, 1'b0, 8'd1,  1'b0, 8'h00},
    '{rc4_pkg::FUNC_DATA, 8'h80, 1'b1, 8'd1,  1'b0, 8'h00},
    '{rc4_pkg::FUNC_KEY,  8'h4B, 1'b0, 8'd1,  1'b0, 8'h00},
    '{rc4_pkg::FUNC_KEY,  8'h65, 1'b0, 8'd1,  1'b0, 8'h00},
    '{FuncNone,           8'h00, 1'b0, 8'd1,  1'b0, 8'h00},
    '{rc4_pkg::FUNC_KEY,  8'h79, 1'b1, 8'd1,  1'b0, 8'h00},
    '{rc4_pkg::FUNC_KS,   8'h00, 1'b0, 8'd1,  1'b0, 8'h00},
    '{rc4_pkg::FUNC_DATA, 8'h6C, 1'b0, 8'd1,  1'b0, 8'h00},
    '{rc4_pkg::FUNC_KS,   8'h00, 1'b1, 8'd1,  1'b0, 8'h00},
    '{rc4_pkg::FUNC_KEY,  8'hFF, 1'b0, 8'd39, 1'b0, 8'h00},
    '{rc4_pkg::FUNC_KEY,  8'h00, 1'b1, 8'd1,  1'b0, 8'h00},
    '{rc4_pkg::FUNC_DATA, 8'h55, 1'b0, 8'd1,  1'b0, 8'h00},
    '{rc4_pkg::FUNC_KS,   8'hAA, 1'b1, 8'd1,  1'b0, 8'h00},
    '{rc4_pkg::FUNC_KEY,  8'hA5, 1'b1, 8'd1,  1'b0, 8'h00},
    '{rc4_pkg::FUNC_DATA, 8'hFF, 1'b1, 8'd1,  1'b0, 8'h00},
    '{rc4_pkg::FUNC_KEY,  8'h01, 1'b0, 8'd32, 1'b0, 8'h00},
    '{rc4_pkg::FUNC_KEY,  8'h02, 1'b1, 8'd1,  1'b0, 8'h00},
    '{rc4_pkg::FUNC_KS,   8'h00, 1'b0, 8'd1,  1'b0, 8'h00},
    '{rc4_pkg::FUNC_DATA, 8'h01, 1'b1, 8'd1,  1'b0, 8'h00}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rc4_in_if  in_if ();
  rc4_out_if out_if ();

  rc4_stream_cipher_core #(
    .KeyBytesMax(KeyMax)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  logic [ByteW-1:0] perm_tab [PermSize];
  logic [ByteW-1:0] key_mem  [KeyMax];
  int               key_cnt;
  logic [ByteW-1:0] gen_i;
  logic [ByteW-1:0] gen_j;

  cipher_out_t expected_out [$];
  cipher_out_t seen;
  logic [ByteW-1:0] ks_byte;

  logic             known_pend;
  logic [ByteW-1:0] known_exp;
  bit               hold_done    = 1'b0;
  int               hold_left    = 0;
  int               send_idle;
  int               recv_idle;
  int               beats_sent   = 0;
  int               results_seen = 0;
  int               sched_count  = 0;
  int               err_count    = 0;

  function automatic void model_reset();
    for (int n = 0; n < PermSize; n++) perm_tab[n] = ByteW'(n);
    for (int n = 0; n < KeyMax; n++) key_mem[n] = '0;
    key_cnt = 0;
    gen_i   = '0;
    gen_j   = '0;
  endfunction

  function automatic bit cipher_step(input logic [FuncW-1:0] f, input logic [ByteW-1:0] d,
                                     input logic l, output logic [ByteW-1:0] r);
    logic [ByteW-1:0] tmp;
    logic [ByteW-1:0] jj;
    logic [ByteW-1:0] sum_idx;
    r = '0;
    case (f)
      rc4_pkg::FUNC_KEY: begin
        if (key_cnt < KeyMax) begin
          key_mem[key_cnt] = d;
          key_cnt++;
        end
        if (l) begin
          for (int n = 0; n < PermSize; n++) perm_tab[n] = ByteW'(n);
          jj = '0;
          for (int n = 0; n < PermSize; n++) begin
            jj = jj + perm_tab[n] + key_mem[n % key_cnt];
            tmp = perm_tab[n];
            perm_tab[n] = perm_tab[jj];
            perm_tab[jj] = tmp;
          end
          gen_i = '0;
          gen_j = '0;
          key_cnt = 0;
          sched_count++;
        end
        return 1'b0;
      end
      rc4_pkg::FUNC_DATA, rc4_pkg::FUNC_KS: begin
        gen_i = gen_i + 8'd1;
        gen_j = gen_j + perm_tab[gen_i];
        tmp = perm_tab[gen_i];
        perm_tab[gen_i] = perm_tab[gen_j];
        perm_tab[gen_j] = tmp;
        sum_idx = perm_tab[gen_i] + perm_tab[gen_j];
        r = (f == rc4_pkg::FUNC_KS) ? perm_tab[sum_idx] : (d ^ perm_tab[sum_idx]);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      model_reset();
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (expected_out.size() == 0) begin
          $error("unexpected beat: data_out %02h last_out %0b", out_if.data_out,
                 out_if.last_out);
          err_count++;
        end else begin
          seen = expected_out.pop_front();
          if (out_if.data_out !== seen.data) begin
            $error("data_out: expected %02h, actual %02h", seen.data, out_if.data_out);
            err_count++;
          end
          if (out_if.last_out !== seen.last) begin
            $error("last_out: expected %0b, actual %0b", seen.last, out_if.last_out);
            err_count++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        if (cipher_step(in_if.func, in_if.data_in, in_if.last, ks_byte)) begin
          seen.data = known_pend ? known_exp : ks_byte;
          seen.last = in_if.last;
          expected_out.push_back(seen);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (!hold_done && beats_sent >= PhaseThreeAt) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_beat(input logic [FuncW-1:0] f, input logic [ByteW-1:0] d,
                           input logic l, input logic known, input logic [ByteW-1:0] exp);
    if (beats_sent == PhaseTwoAt) begin
      send_idle = 78;
      recv_idle = 34;
    end
    if (beats_sent == PhaseThreeAt) begin
      send_idle = 0;
      recv_idle = 0;
    end
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.func    <= f;
    in_if.data_in <= d;
    in_if.last    <= l;
    known_pend    <= known;
    known_exp     <= exp;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    beats_sent++;
  endtask

  initial begin
    #(LimitCycles * ClkPeriod);
    $display("testbench failed");
    $finish;
  end

  initial begin
    int rand_start;
    int pick;
    int klen;
    int dlen;
    logic [FuncW-1:0] f;
    send_idle     = 34;
    recv_idle     = 78;
    known_pend    <= 1'b0;
    known_exp     <= '0;
    in_if.valid   <= 1'b0;
    in_if.func    <= rc4_pkg::FUNC_KEY;
    in_if.data_in <= '0;
    in_if.last    <= 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      repeat (DirRows[r].reps) begin
        send_beat(DirRows[r].func, DirRows[r].data, DirRows[r].last, DirRows[r].known,
                  DirRows[r].exp);
      end
    end

    rand_start = beats_sent;
    while (beats_sent - rand_start < NumRandom) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        case ($urandom_range(9))
          0:       klen = $urandom_range(KeyMax + 1, KeyMax + 12);
          1:       klen = KeyMax;
          2:       klen = 1;
          default: klen = $urandom_range(2, 16);
        endcase
        for (int k = 0; k < klen; k++) begin
          send_beat(rc4_pkg::FUNC_KEY, ByteW'($urandom), k == klen - 1, 1'b0, '0);
        end
      end
      if (pick < 92) begin
        dlen = $urandom_range(1, 32);
        for (int k = 0; k < dlen; k++) begin
          f = $urandom_range(1) ? rc4_pkg::FUNC_DATA : rc4_pkg::FUNC_KS;
          send_beat(f, ByteW'($urandom), (k == dlen - 1) || ($urandom_range(7) == 0),
                    1'b0, '0);
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_beat(FuncW'($urandom), ByteW'($urandom), 1'($urandom), 1'b0, '0);
        end
      end
    end
    in_if.valid <= 1'b0;

    while (expected_out.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run covered %0d input beats, %0d output beats, %0d key schedules",
             beats_sent, results_seen, sched_count);
    if (err_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
